### rtl/osa_pkg.sv
// Shared types and codes for the ordered slot array.
`timescale 1ns / 1ps
package osa_pkg;

  localparam int POS_BITS = 11;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_FIND    = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_MOVE    = 3'd5,
    CMD_CLEAR   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2,
    STS_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_UP   = 2'd0,
    MODE_DOWN = 2'd1,
    MODE_ZERO = 2'd2
  } region_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EVAL  = 2'd1,
    ST_APPLY = 2'd2
  } osa_state_t;

  typedef struct packed {
    logic         region_en;
    region_mode_t mode;
    pos_t         lo;
    pos_t         hi;
    logic         load_en;
    pos_t         load_idx;
    pos_t         rd_idx;
    pos_t         fill;
  } cell_ctl_t;

endpackage

### rtl/ordered_slot_array_unit.sv
// Top level of the ordered slot array: command sequencer, row of cells, result register.
//
// Channel  Dir  Beat contents
// s_axis   in   command, position, second_position, word_value
// m_axis   out  status, read_word, found_index, occupied
//
// A command passes an evaluate step, which compares and reads across all cells, and an
// apply step, which shifts the row and places the result; the next beat is taken as it completes.
// A remove stays in apply while the row shifts down one place a cycle, once per entry.
// Reset clears the count and control state; slot contents are not cleared.
// A stalled output holds the block in its apply step and the input waits with it.
`timescale 1ns / 1ps
module ordered_slot_array_unit #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], position[9:3], second_position[16:10], word_value[48:17], zero[55:49]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], read_word[33:2], found_index[39:34], occupied[46:40], zero[47]
  output logic [47:0] m_axis_tdata
);
  import osa_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam pos_t CAP_P = pos_t'(CAPACITY);

  osa_state_t state, state_next;

  cmd_t        cmd_q;
  logic [6:0]  pos_q;
  logic [6:0]  pos2_q;
  logic [31:0] val_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_next;
  pos_t        run_left;
  logic [CAPACITY-1:0] match_q;
  logic [WORD_BITS-1:0] tmp_q;

  logic [1:0]  out_status_q;
  logic [31:0] out_rword_q;
  logic [5:0]  out_fidx_q;
  logic [6:0]  out_occ_q;

  logic in_accept, out_free, apply_fire, cell_go;
  cell_ctl_t ctl_raw, cell_ctl;
  status_t status_next;
  logic [31:0] rword_next;
  logic [5:0]  fidx_next;
  pos_t p, p2, n, rem, run_len;

  logic [WORD_BITS-1:0] key, load_data;
  logic [WORD_BITS-1:0] slot_w [CAPACITY];
  logic [WORD_BITS-1:0] read_w [CAPACITY];
  logic [CAPACITY-1:0]  match_w;
  logic [WORD_BITS-1:0] read_any;
  logic [CAPACITY-1:0]  first_hit;
  logic [IW-1:0]        hit_idx;

  assign p   = pos_t'(pos_q);
  assign p2  = pos_t'(pos2_q);
  assign n   = pos_t'(count_q);
  assign rem = n - p;
  assign run_len = (p < n) ? ((p2 < rem) ? p2 : rem) : '0;

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign apply_fire = (state == ST_APPLY) && (run_left == '0) && out_free;
  assign s_axis_tready = (state == ST_IDLE) || apply_fire;
  assign in_accept  = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_accept) state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_APPLY;
      ST_APPLY: begin
        if (apply_fire) begin
          state_next = in_accept ? ST_EVAL : ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q  <= cmd_t'(s_axis_tdata[2:0]);
      pos_q  <= s_axis_tdata[9:3];
      pos2_q <= s_axis_tdata[16:10];
      val_q  <= s_axis_tdata[48:17];
    end
    if (state == ST_EVAL) begin
      match_q <= match_w;
      tmp_q   <= read_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_left <= '0;
      count_q  <= '0;
    end else begin
      if (state == ST_EVAL) begin
        run_left <= (cmd_q == CMD_REMOVE) ? run_len : '0;
      end else if ((state == ST_APPLY) && (run_left != '0)) begin
        run_left <= run_left - pos_t'(1);
      end
      if (apply_fire) begin
        count_q <= count_next;
      end
    end
  end

  always_comb begin
    first_hit = match_q & (~match_q + CAPACITY'(1));
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_idx = hit_idx | (first_hit[i] ? IW'(i) : '0);
    end
    read_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_any = read_any | read_w[i];
    end
  end

  always_comb begin
    ctl_raw          = '0;
    ctl_raw.rd_idx   = p;
    ctl_raw.fill     = n;
    status_next      = STS_OK;
    rword_next       = '0;
    fidx_next        = '0;
    count_next       = count_q;
    load_data        = WORD_BITS'(val_q);
    case (cmd_q)
      CMD_READ: begin
        if (p < n) begin
          rword_next = 32'(tmp_q);
        end else begin
          status_next = STS_RANGE;
        end
      end
      CMD_FIND: begin
        if (|match_q) begin
          fidx_next = 6'(hit_idx);
        end else begin
          status_next = STS_MISS;
        end
      end
      CMD_INSERT: begin
        if (p > n) begin
          status_next = STS_RANGE;
        end else if (n >= CAP_P) begin
          status_next = STS_FULL;
        end else begin
          ctl_raw.region_en = 1'b1;
          ctl_raw.mode      = MODE_UP;
          ctl_raw.lo        = p + pos_t'(1);
          ctl_raw.hi        = n;
          ctl_raw.load_en   = 1'b1;
          ctl_raw.load_idx  = p;
          count_next        = count_q + CW'(1);
        end
      end
      CMD_REPLACE: begin
        if (p >= CAP_P) begin
          status_next = STS_FULL;
        end else begin
          ctl_raw.region_en = (p > n);
          ctl_raw.mode      = MODE_ZERO;
          ctl_raw.lo        = n;
          ctl_raw.hi        = p - pos_t'(1);
          ctl_raw.load_en   = 1'b1;
          ctl_raw.load_idx  = p;
          if (p >= n) begin
            count_next = CW'(p + pos_t'(1));
          end
        end
      end
      CMD_REMOVE: begin
        if (p >= n) begin
          status_next = STS_RANGE;
        end else begin
          ctl_raw.region_en = (run_left != '0);
          ctl_raw.mode      = MODE_DOWN;
          ctl_raw.lo        = p;
          ctl_raw.hi        = CAP_P - pos_t'(1);
          count_next        = count_q - CW'(run_len);
        end
      end
      CMD_MOVE: begin
        if (p == p2) begin
          status_next = STS_OK;
        end else if ((p >= n) || (p2 >= n)) begin
          status_next = STS_RANGE;
        end else begin
          ctl_raw.region_en = 1'b1;
          ctl_raw.load_en   = 1'b1;
          ctl_raw.load_idx  = p2;
          load_data         = tmp_q;
          if (p2 < p) begin
            ctl_raw.mode = MODE_UP;
            ctl_raw.lo   = p2 + pos_t'(1);
            ctl_raw.hi   = p;
          end else begin
            ctl_raw.mode = MODE_DOWN;
            ctl_raw.lo   = p;
            ctl_raw.hi   = p2 - pos_t'(1);
          end
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = STS_RANGE;
      end
    endcase
  end

  assign cell_go = (state == ST_APPLY) && ((cmd_q == CMD_REMOVE) || apply_fire);

  always_comb begin
    cell_ctl           = ctl_raw;
    cell_ctl.region_en = ctl_raw.region_en && cell_go;
    cell_ctl.load_en   = ctl_raw.load_en && apply_fire;
  end

  assign key = WORD_BITS'(val_q);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = slot_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = slot_w[i+1];
    end
    osa_cell #(
      .WORD_BITS (WORD_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .load_data (load_data),
      .key       (key),
      .left      (left_w),
      .right     (right_w),
      .slot      (slot_w[i]),
      .match     (match_w[i]),
      .read_part (read_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (apply_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      out_status_q <= status_next;
      out_rword_q  <= rword_next;
      out_fidx_q   <= fidx_next;
      out_occ_q    <= 7'(count_next);
    end
  end

  assign m_axis_tdata = {1'b0, out_occ_q, out_fidx_q, out_rword_q, out_status_q};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= CW'(CAPACITY))
    else $error("Fill count exceeds capacity.");

  a_no_accept_while_shifting: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) && (run_left != '0) |-> !s_axis_tready)
    else $error("Input taken while a remove is still shifting.");

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_APPLY)
    else $error("Result appeared outside the apply step.");

  a_count_only_on_apply: assert property (@(posedge clk) disable iff (rst)
    !apply_fire |=> $stable(count_q))
    else $error("Fill count changed without a completed command.");

endmodule

### rtl/osa_cell.sv
// One slot of the array: holds or loads a word, shifts from a neighbor or clears, compares and reads.
`timescale 1ns / 1ps
module osa_cell #(
  parameter int WORD_BITS = 32,
  parameter int INDEX     = 0
) (
  input  logic                  clk,
  input  osa_pkg::cell_ctl_t    ctl,
  input  logic [WORD_BITS-1:0]  load_data,
  input  logic [WORD_BITS-1:0]  key,
  input  logic [WORD_BITS-1:0]  left,
  input  logic [WORD_BITS-1:0]  right,
  output logic [WORD_BITS-1:0]  slot,
  output logic                  match,
  output logic [WORD_BITS-1:0]  read_part
);
  import osa_pkg::*;

  localparam pos_t MY_IDX = pos_t'(INDEX);

  logic [WORD_BITS-1:0] slot_q;
  logic [WORD_BITS-1:0] slot_next;

  always_comb begin
    slot_next = slot_q;
    if (ctl.load_en && (ctl.load_idx == MY_IDX)) begin
      slot_next = load_data;
    end else if (ctl.region_en && (MY_IDX >= ctl.lo) && (MY_IDX <= ctl.hi)) begin
      case (ctl.mode)
        MODE_UP:   slot_next = left;
        MODE_DOWN: slot_next = right;
        MODE_ZERO: slot_next = '0;
        default:   slot_next = slot_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    slot_q <= slot_next;
  end

  assign slot      = slot_q;
  assign match     = (slot_q == key) && (MY_IDX < ctl.fill);
  assign read_part = (ctl.rd_idx == MY_IDX) ? slot_q : '0;

endmodule

### sim/testbench.sv
// Self-checking testbench for the ordered slot array: directed and random commands, scored per beat.
`timescale 1ns / 1ps
module testbench;
  import osa_pkg::*;

  localparam int SLOTS = 64;
  localparam int RANDOM_COMMANDS = 1750;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int STIM_COPY = 0;
  localparam int CHECK_COPY = 1;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]  command;
    logic [6:0]  position;
    logic [6:0]  second_position;
    logic [31:0] word_value;
  } slot_cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] read_word;
    logic [5:0]  found_index;
    logic [6:0]  occupied;
  } slot_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  // Two images of the array: one steers stimulus, one scores the replies.
  logic [31:0] slot_image [2][SLOTS];
  int          fill_image [2];

  slot_cmd_t   pending_cmds [$];
  slot_reply_t expected_replies [$];
  int          total_cmds = 0;
  int          cmds_accepted = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_phase = 0;

  ordered_slot_array_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk = ~clk;

  function automatic slot_reply_t apply_command(input int img, input slot_cmd_t c);
    slot_reply_t r;
    int n, p, q, run, i;
    logic [31:0] held;
    n = fill_image[img];
    p = int'(c.position);
    q = int'(c.second_position);
    r.status = STS_OK;
    r.read_word = '0;
    r.found_index = '0;
    case (c.command)
      CMD_READ: begin
        if (p < n) r.read_word = slot_image[img][p];
        else r.status = STS_RANGE;
      end
      CMD_FIND: begin
        r.status = STS_MISS;
        for (i = 0; i < n; i++) begin
          if (slot_image[img][i] == c.word_value) begin
            r.status = STS_OK;
            r.found_index = i[5:0];
            break;
          end
        end
      end
      CMD_INSERT: begin
        if (p > n) begin
          r.status = STS_RANGE;
        end else if (n >= SLOTS) begin
          r.status = STS_FULL;
        end else begin
          for (i = n; i > p; i--) slot_image[img][i] = slot_image[img][i-1];
          slot_image[img][p] = c.word_value;
          fill_image[img] = n + 1;
        end
      end
      CMD_REPLACE: begin
        if (p >= SLOTS) begin
          r.status = STS_FULL;
        end else begin
          for (i = n; i < p; i++) slot_image[img][i] = '0;
          slot_image[img][p] = c.word_value;
          if (p >= n) fill_image[img] = p + 1;
        end
      end
      CMD_REMOVE: begin
        if (p >= n) begin
          r.status = STS_RANGE;
        end else begin
          run = (q > n - p) ? n - p : q;
          for (i = p; i + run < n; i++) slot_image[img][i] = slot_image[img][i+run];
          fill_image[img] = n - run;
        end
      end
      CMD_MOVE: begin
        if (p != q) begin
          if (p >= n || q >= n) begin
            r.status = STS_RANGE;
          end else begin
            held = slot_image[img][p];
            if (q < p) for (i = p; i > q; i--) slot_image[img][i] = slot_image[img][i-1];
            else for (i = p; i < q; i++) slot_image[img][i] = slot_image[img][i+1];
            slot_image[img][q] = held;
          end
        end
      end
      CMD_CLEAR: fill_image[img] = 0;
      default: r.status = STS_RANGE;
    endcase
    r.occupied = fill_image[img][6:0];
    return r;
  endfunction

  task automatic queue_command(input logic [2:0] command, input int position,
                               input int second_position, input logic [31:0] word_value);
    slot_cmd_t c;
    c.command = command;
    c.position = position[6:0];
    c.second_position = second_position[6:0];
    c.word_value = word_value;
    pending_cmds.push_back(c);
    void'(apply_command(STIM_COPY, c));
    total_cmds++;
  endtask

  function automatic logic [31:0] pick_word(input int n);
    int coin;
    coin = $urandom_range(0, 99);
    if (coin < 30 && n > 0) return slot_image[STIM_COPY][$urandom_range(0, n - 1)];
    if (coin < 60) return 32'($urandom_range(0, 7));
    if (coin < 65) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic queue_random_command(input bit growing);
    int n, roll, p, q;
    n = fill_image[STIM_COPY];
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 8) begin
      queue_command(3'($urandom), $urandom, $urandom, $urandom);
    end else if (roll < (growing ? 30 : 16)) begin
      p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, n);
      queue_command(CMD_INSERT, p, $urandom, pick_word(n));
    end else if (roll < (growing ? 40 : 26)) begin
      p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                       : $urandom_range(0, (n + 4 > 63) ? 63 : n + 4);
      queue_command(CMD_REPLACE, p, $urandom, pick_word(n));
    end else if (roll < (growing ? 44 : 42)) begin
      q = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
      queue_command(CMD_REMOVE, $urandom_range(0, n), q, $urandom);
    end else if (roll < 60) begin
      queue_command(CMD_MOVE, $urandom_range(0, n), $urandom_range(0, n), $urandom);
    end else if (roll < 77) begin
      queue_command(CMD_READ, $urandom_range(0, n), $urandom, $urandom);
    end else if (roll < 98) begin
      queue_command(CMD_FIND, $urandom, $urandom, pick_word(n));
    end else if (roll < 99) begin
      queue_command(CMD_CLEAR, $urandom, $urandom, $urandom);
    end else begin
      queue_command(CMD_UNUSED, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("tb: mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  function automatic int sender_idle_pct(input int phase);
    case (phase)
      1: return 82;
      3: return 24;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input int phase);
    case (phase)
      2: return 82;
      3: return 24;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin : drive_commands
    slot_cmd_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        nxt.command = s_axis_tdata[2:0];
        nxt.position = s_axis_tdata[9:3];
        nxt.second_position = s_axis_tdata[16:10];
        nxt.word_value = s_axis_tdata[48:17];
        expected_replies.push_back(apply_command(CHECK_COPY, nxt));
        cmds_accepted++;
        idle_phase <= (cmds_accepted / 110) % 5;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct(idle_phase)) begin
          nxt = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'b0, nxt.word_value, nxt.second_position, nxt.position,
                           nxt.command};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct(idle_phase));
  end

  always @(posedge clk) begin : score_replies
    slot_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply beat with no command outstanding");
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata[1:0] !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tdata[1:0], want.status));
        if (m_axis_tdata[33:2] !== want.read_word)
          report_mismatch($sformatf("read_word %h, want %h", m_axis_tdata[33:2],
                                    want.read_word));
        if (m_axis_tdata[39:34] !== want.found_index)
          report_mismatch($sformatf("found_index %0d, want %0d", m_axis_tdata[39:34],
                                    want.found_index));
        if (m_axis_tdata[46:40] !== want.occupied)
          report_mismatch($sformatf("occupied %0d, want %0d", m_axis_tdata[46:40],
                                    want.occupied));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_image[STIM_COPY][i] = '0;
      slot_image[CHECK_COPY][i] = '0;
    end
    fill_image[STIM_COPY] = 0;
    fill_image[CHECK_COPY] = 0;

    // Empty array: reads, removes and moves are out of range, a find misses, a move onto itself is still fine.
    queue_command(CMD_READ, 0, 0, 32'h0);
    queue_command(CMD_FIND, 0, 0, 32'h0);
    queue_command(CMD_REMOVE, 0, 1, 32'h0);
    queue_command(CMD_MOVE, 127, 127, 32'h0);
    queue_command(CMD_MOVE, 3, 5, 32'h0);
    queue_command(CMD_INSERT, 1, 0, 32'h1);
    queue_command(CMD_INSERT, 0, 0, 32'hFFFF_FFFF);
    queue_command(CMD_INSERT, 1, 0, 32'h0);
    queue_command(CMD_INSERT, 0, 0, 32'h1234_5678);
    // A replace far past the count zero-fills the gap and fills the array.
    queue_command(CMD_REPLACE, 63, 0, 32'hA5A5_A5A5);
    queue_command(CMD_INSERT, 127, 0, 32'h1);
    queue_command(CMD_INSERT, 10, 0, 32'h1);
    queue_command(CMD_REPLACE, 64, 0, 32'h1);
    queue_command(CMD_REPLACE, 127, 127, 32'hFFFF_FFFF);
    queue_command(CMD_READ, 63, 0, 32'h0);
    queue_command(CMD_READ, 127, 0, 32'h0);
    queue_command(CMD_FIND, 0, 0, 32'hA5A5_A5A5);
    queue_command(CMD_FIND, 0, 0, 32'h0);
    queue_command(CMD_MOVE, 63, 0, 32'h0);
    queue_command(CMD_MOVE, 0, 63, 32'h0);
    queue_command(CMD_REMOVE, 60, 127, 32'h0);
    queue_command(CMD_REMOVE, 5, 0, 32'h0);
    queue_command(CMD_UNUSED, 0, 0, 32'h0);
    queue_command(CMD_CLEAR, 0, 0, 32'h0);
    queue_command(CMD_READ, 0, 0, 32'h0);

    for (int k = 0; k < RANDOM_COMMANDS; k++) queue_random_command(((k / 150) % 2) == 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (cmds_accepted < total_cmds || expected_replies.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/osa_pkg.sv
rtl/osa_cell.sv
rtl/ordered_slot_array_unit.sv
sim/testbench.sv
